// ===== rtl/line_position_pid_steering_top_assert.svh =====
// ----------------------------------------------------------------------------
// line position pid steering assertion macros
// shared property forms for the steering block checks
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_PID_STEERING_TOP_ASSERT_SVH
`define LINE_POSITION_PID_STEERING_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LPPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lpps check failed in the same cycle");

// next-cycle implication, disabled while in reset
`define LPPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lpps check failed in the next cycle");

`endif

// ===== rtl/lpps_pkg.sv =====
// ----------------------------------------------------------------------------
// lpps_pkg
// widths, register indexes and sensor weights of the line steering block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpps_pkg;

    // sensor array
    localparam int SENSOR_COUNT = 6;
    localparam int READING_BITS = 12;

    // fixed field widths
    localparam int THRESH_W = 12;
    localparam int SPEED_W  = 16;
    localparam int ERR_W    = 16;
    localparam int GAIN_W   = 24;
    localparam int INTEG_W  = 48;

    // correction scaling: product shifted right gives q8.8 speed
    localparam int GAIN_SHIFT = 16;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINE_THRESHOLD = 3'd0,
        CFG_BASE_SPEED     = 3'd1,
        CFG_PROP_GAIN      = 3'd2,
        CFG_INTEG_GAIN     = 3'd3,
        CFG_DERIV_GAIN     = 3'd4
    } cfg_index_t;

    // register reset values
    localparam logic [THRESH_W-1:0]      LINE_THRESHOLD_RST = 12'd1700;
    localparam logic signed [SPEED_W-1:0] BASE_SPEED_RST    = 16'sd2560;
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST      = 24'sd6711;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST     = 24'sd0;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST     = 24'sd0;

    // position weights, leftmost sensor first
    localparam logic signed [3:0] LINE_WEIGHT [SENSOR_COUNT] =
        '{-4'sd4, -4'sd2, -4'sd1, 4'sd1, 4'sd2, 4'sd4};

endpackage

`default_nettype wire

// ===== rtl/line_position_pid_steering_top.sv =====
// ----------------------------------------------------------------------------
// line_position_pid_steering_top
// line position error, pid correction and differential wheel speeds
// ----------------------------------------------------------------------------
// Each request carries six reflectance readings and gives one result: the
// right and left wheel speed setpoints, the line-seen flag and the weighted
// position error. The block is a six-register pipeline (input, error,
// products, integral, correction, result) taking one request per clock while
// the result side does not stall; stalls back up stage by stage, so bubbles
// are squeezed out. The integral register alone closes its loop (one 49-bit
// add and saturate), so a frame can follow the previous one directly.
// The user must write configuration registers through the cfg port while no
// request is in flight; the block does not enforce this. The cfg port is
// always ready and ignores unknown indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "line_position_pid_steering_top_assert.svh"

module line_position_pid_steering_top #(
    parameter int READING_BITS = lpps_pkg::READING_BITS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    // configuration write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [lpps_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [lpps_pkg::CFG_DATA_W-1:0]        cfg_data,

    // sensor frame channel
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [READING_BITS-1:0]                s_reading_0,
    input  wire logic [READING_BITS-1:0]                s_reading_1,
    input  wire logic [READING_BITS-1:0]                s_reading_2,
    input  wire logic [READING_BITS-1:0]                s_reading_3,
    input  wire logic [READING_BITS-1:0]                s_reading_4,
    input  wire logic [READING_BITS-1:0]                s_reading_5,

    // wheel speed channel
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [lpps_pkg::SPEED_W-1:0]         m_right_speed,
    output logic signed [lpps_pkg::SPEED_W-1:0]         m_left_speed,
    output logic                                        m_line_seen,
    output logic signed [lpps_pkg::ERR_W-1:0]           m_line_error
);

    localparam int SC      = lpps_pkg::SENSOR_COUNT;
    localparam int ERR_W   = lpps_pkg::ERR_W;
    localparam int SPEED_W = lpps_pkg::SPEED_W;
    localparam int GAIN_W  = lpps_pkg::GAIN_W;
    localparam int INTEG_W = lpps_pkg::INTEG_W;
    localparam int THR_W   = lpps_pkg::THRESH_W;

    // weighted sum: |sum| <= 7 * max reading
    localparam int ESUM_W = READING_BITS + 5;
    localparam int EXT_W  = (ESUM_W > ERR_W) ? ESUM_W : ERR_W + 1;
    localparam int CMP_W  = (READING_BITS > THR_W) ? READING_BITS : THR_W;
    localparam int DIFF_W = ERR_W + 1;
    localparam int P_W    = GAIN_W + ERR_W;
    localparam int D_W    = GAIN_W + DIFF_W;
    localparam int PD_W   = D_W + 1;
    localparam int ISUM_W = INTEG_W + 1;
    localparam int TOT_W  = ((PD_W > INTEG_W) ? PD_W : INTEG_W) + 1;
    localparam int CORR_W = TOT_W - lpps_pkg::GAIN_SHIFT;
    localparam int SPD_X_W = ((CORR_W > SPEED_W) ? CORR_W : SPEED_W) + 1;

    localparam logic signed [EXT_W-1:0] ERR_HI = EXT_W'((2 ** (ERR_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] ERR_LO = -ERR_HI - EXT_W'(1);
    localparam logic signed [ISUM_W-1:0] INT_HI = ISUM_W'((64'sd1 <<< (INTEG_W - 1)) - 1);
    localparam logic signed [ISUM_W-1:0] INT_LO = -INT_HI - ISUM_W'(1);
    localparam logic signed [SPD_X_W-1:0] SPD_HI = SPD_X_W'((2 ** (SPEED_W - 1)) - 1);
    localparam logic signed [SPD_X_W-1:0] SPD_LO = -SPD_HI - SPD_X_W'(1);

    // configuration registers
    logic [THR_W-1:0]          thresh_reg;
    logic signed [SPEED_W-1:0] base_reg;
    logic signed [GAIN_W-1:0]  kp_reg;
    logic signed [GAIN_W-1:0]  ki_reg;
    logic signed [GAIN_W-1:0]  kd_reg;

    // pid state
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    // stage valids and advance enables
    logic in_v_reg, e_v_reg, m_v_reg, i_v_reg, c_v_reg, out_v_reg;
    logic go_in, go_e, go_m, go_i, go_c, go_out;

    // input stage
    logic [READING_BITS-1:0] rd_reg [SC];

    // error stage
    logic                     e_seen_reg, e_seen_next;
    logic signed [ERR_W-1:0]  e_err_reg, e_err_next;
    logic signed [DIFF_W-1:0] e_diff_reg, e_diff_next;
    logic signed [ESUM_W-1:0] esum;
    logic signed [EXT_W-1:0]  esum_ext;

    // product stage
    logic                     m_seen_reg;
    logic signed [ERR_W-1:0]  m_err_reg;
    logic signed [P_W-1:0]    m_p_reg, m_p_next;
    logic signed [P_W-1:0]    m_i_reg, m_i_next;
    logic signed [D_W-1:0]    m_d_reg, m_d_next;

    // integral stage
    logic                      i_seen_reg;
    logic signed [ERR_W-1:0]   i_err_reg;
    logic signed [PD_W-1:0]    i_pd_reg, i_pd_next;
    logic signed [INTEG_W-1:0] i_int_reg, integ_next;
    logic signed [ISUM_W-1:0]  isum;
    logic                      int_load;

    // correction stage
    logic                      c_seen_reg;
    logic signed [ERR_W-1:0]   c_err_reg;
    logic signed [CORR_W-1:0]  c_corr_reg, c_corr_next;
    logic signed [TOT_W-1:0]   total;

    // result stage
    logic signed [SPEED_W-1:0] right_reg, right_next;
    logic signed [SPEED_W-1:0] left_reg, left_next;
    logic                      seen_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [SPD_X_W-1:0] right_x, left_x;

    logic prev_load;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= lpps_pkg::LINE_THRESHOLD_RST;
            base_reg   <= lpps_pkg::BASE_SPEED_RST;
            kp_reg     <= lpps_pkg::PROP_GAIN_RST;
            ki_reg     <= lpps_pkg::INTEG_GAIN_RST;
            kd_reg     <= lpps_pkg::DERIV_GAIN_RST;
        end else if (cfg_valid) begin
            case (lpps_pkg::cfg_index_t'(cfg_index))
                lpps_pkg::CFG_LINE_THRESHOLD: thresh_reg <= cfg_data[THR_W-1:0];
                lpps_pkg::CFG_BASE_SPEED:     base_reg   <= cfg_data[SPEED_W-1:0];
                lpps_pkg::CFG_PROP_GAIN:      kp_reg     <= cfg_data[GAIN_W-1:0];
                lpps_pkg::CFG_INTEG_GAIN:     ki_reg     <= cfg_data[GAIN_W-1:0];
                lpps_pkg::CFG_DERIV_GAIN:     kd_reg     <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // advance chain from the result side back to the input
    assign go_out  = m_ready || !out_v_reg;
    assign go_c    = go_out || !c_v_reg;
    assign go_i    = go_c || !i_v_reg;
    assign go_m    = go_i || !m_v_reg;
    assign go_e    = go_m || !e_v_reg;
    assign go_in   = go_e || !in_v_reg;
    assign s_ready = go_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            e_v_reg   <= 1'b0;
            m_v_reg   <= 1'b0;
            i_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (go_in)  in_v_reg  <= s_valid;
            if (go_e)   e_v_reg   <= in_v_reg;
            if (go_m)   m_v_reg   <= e_v_reg;
            if (go_i)   i_v_reg   <= m_v_reg;
            if (go_c)   c_v_reg   <= i_v_reg;
            if (go_out) out_v_reg <= c_v_reg;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (go_in && s_valid) begin
            rd_reg[0] <= s_reading_0;
            rd_reg[1] <= s_reading_1;
            rd_reg[2] <= s_reading_2;
            rd_reg[3] <= s_reading_3;
            rd_reg[4] <= s_reading_4;
            rd_reg[5] <= s_reading_5;
        end
    end

    // line detect and weighted position error
    always_comb begin
        esum        = '0;
        e_seen_next = 1'b0;
        for (int i = 0; i < SC; i++) begin
            if (CMP_W'(rd_reg[i]) < CMP_W'(thresh_reg))
                e_seen_next = 1'b1;
            esum = esum + ESUM_W'(signed'({1'b0, rd_reg[i]}))
                        * ESUM_W'(lpps_pkg::LINE_WEIGHT[i]);
        end
        esum_ext = EXT_W'(esum);
        if (!e_seen_next)
            e_err_next = '0;
        else if (esum_ext > ERR_HI)
            e_err_next = ERR_HI[ERR_W-1:0];
        else if (esum_ext < ERR_LO)
            e_err_next = ERR_LO[ERR_W-1:0];
        else
            e_err_next = esum_ext[ERR_W-1:0];
        e_diff_next = DIFF_W'(e_err_next) - DIFF_W'(prev_err_reg);
    end

    assign prev_load = go_e && in_v_reg && e_seen_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            prev_err_reg <= '0;
        else if (prev_load)
            prev_err_reg <= e_err_next;
    end

    always_ff @(posedge aclk) begin
        if (go_e) begin
            e_seen_reg <= e_seen_next;
            e_err_reg  <= e_err_next;
            e_diff_reg <= e_diff_next;
        end
    end

    // gain products
    assign m_p_next = P_W'(kp_reg) * P_W'(e_err_reg);
    assign m_i_next = P_W'(ki_reg) * P_W'(e_err_reg);
    assign m_d_next = D_W'(kd_reg) * D_W'(e_diff_reg);

    always_ff @(posedge aclk) begin
        if (go_m) begin
            m_seen_reg <= e_seen_reg;
            m_err_reg  <= e_err_reg;
            m_p_reg    <= m_p_next;
            m_i_reg    <= m_i_next;
            m_d_reg    <= m_d_next;
        end
    end

    // saturating integral update and p plus d
    always_comb begin
        isum = ISUM_W'(integ_reg) + ISUM_W'(m_i_reg);
        if (!m_seen_reg)
            integ_next = integ_reg;
        else if (isum > INT_HI)
            integ_next = INT_HI[INTEG_W-1:0];
        else if (isum < INT_LO)
            integ_next = INT_LO[INTEG_W-1:0];
        else
            integ_next = isum[INTEG_W-1:0];
        i_pd_next = PD_W'(m_p_reg) + PD_W'(m_d_reg);
    end

    assign int_load = go_i && m_v_reg && m_seen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            integ_reg <= '0;
        else if (int_load)
            integ_reg <= integ_next;
    end

    always_ff @(posedge aclk) begin
        if (go_i) begin
            i_seen_reg <= m_seen_reg;
            i_err_reg  <= m_err_reg;
            i_pd_reg   <= i_pd_next;
            i_int_reg  <= integ_next;
        end
    end

    // correction, floor division by the gain scale
    assign total       = TOT_W'(i_pd_reg) + TOT_W'(i_int_reg);
    assign c_corr_next = total[TOT_W-1:lpps_pkg::GAIN_SHIFT];

    always_ff @(posedge aclk) begin
        if (go_c) begin
            c_seen_reg <= i_seen_reg;
            c_err_reg  <= i_err_reg;
            c_corr_reg <= c_corr_next;
        end
    end

    // differential speeds with saturation
    always_comb begin
        right_x = SPD_X_W'(base_reg) + SPD_X_W'(c_corr_reg);
        left_x  = SPD_X_W'(base_reg) - SPD_X_W'(c_corr_reg);
        if (!c_seen_reg)
            right_next = base_reg;
        else if (right_x > SPD_HI)
            right_next = SPD_HI[SPEED_W-1:0];
        else if (right_x < SPD_LO)
            right_next = SPD_LO[SPEED_W-1:0];
        else
            right_next = right_x[SPEED_W-1:0];
        if (!c_seen_reg)
            left_next = base_reg;
        else if (left_x > SPD_HI)
            left_next = SPD_HI[SPEED_W-1:0];
        else if (left_x < SPD_LO)
            left_next = SPD_LO[SPEED_W-1:0];
        else
            left_next = left_x[SPEED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (go_out) begin
            right_reg <= right_next;
            left_reg  <= left_next;
            seen_reg  <= c_seen_reg;
            err_reg   <= c_err_reg;
        end
    end

    // result ports
    assign m_valid       = out_v_reg;
    assign m_right_speed = right_reg;
    assign m_left_speed  = left_reg;
    assign m_line_seen   = seen_reg;
    assign m_line_error  = err_reg;

    // checks
    `LPPS_ASSERT_NOW(a_no_line_base, aclk, aresetn, m_valid && !m_line_seen,
        m_right_speed == m_left_speed && m_line_error == '0)
    `LPPS_ASSERT_NOW(a_empty_takes, aclk, aresetn, !out_v_reg, s_ready)
    `LPPS_ASSERT_NEXT(a_integ_hold, aclk, aresetn, aresetn && !int_load,
        $stable(integ_reg))
    `LPPS_ASSERT_NEXT(a_prev_hold, aclk, aresetn, aresetn && !prev_load,
        $stable(prev_err_reg))

endmodule

`default_nettype wire

// ===== sim/tb_line_position_pid_steering_top.sv =====
// ----------------------------------------------------------------------------
// tb_line_position_pid_steering_top
// self-checking bench for the line position pid steering block
// ----------------------------------------------------------------------------
// Sensor frames go in over a valid/ready request channel, and wheel speed
// results are taken off the result channel with random stalls. A scoreboard
// class keeps its own threshold, base speed, gains, last error and integral.
// For every accepted frame it works out the expected speeds, flag and error.
// Each result is checked field by field against the oldest expectation. The
// run walks through several register settings: reset values, a long push
// that drives the integral into its clamp, never-seen and highest
// thresholds, gain and speed extremes, and random settings. Registers are
// only written once the pipeline has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_line_position_pid_steering_top;

    // package constants used by the bench
    localparam int SENSOR_COUNT = lpps_pkg::SENSOR_COUNT;
    localparam int READING_BITS = lpps_pkg::READING_BITS;
    localparam int THRESH_W     = lpps_pkg::THRESH_W;
    localparam int SPEED_W      = lpps_pkg::SPEED_W;
    localparam int ERR_W        = lpps_pkg::ERR_W;
    localparam int GAIN_W       = lpps_pkg::GAIN_W;
    localparam int INTEG_W      = lpps_pkg::INTEG_W;
    localparam int GAIN_SHIFT   = lpps_pkg::GAIN_SHIFT;
    localparam int CFG_INDEX_W  = lpps_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W   = lpps_pkg::CFG_DATA_W;

    localparam int     PIPE_LATENCY   = 5;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam int     READ_MAX       = 2 ** READING_BITS - 1;
    localparam longint SPEED_HI       = 32767;
    localparam longint SPEED_LO       = -32768;
    localparam longint INTEG_HI       = (longint'(1) << (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO       = -INTEG_HI - 1;

    localparam logic signed [GAIN_W-1:0]  GAIN_MAX  = 24'sh7FFFFF;
    localparam logic signed [GAIN_W-1:0]  GAIN_MIN  = 24'sh800000;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;

    // position weights, leftmost sensor first
    localparam int POS_WEIGHT [SENSOR_COUNT] = '{-4, -2, -1, 1, 2, 4};

    typedef logic [READING_BITS-1:0] frame_t [SENSOR_COUNT];

    typedef struct packed {
        logic signed [SPEED_W-1:0] right;
        logic signed [SPEED_W-1:0] left;
        logic                      seen;
        logic signed [ERR_W-1:0]   err;
    } wheel_result_t;

    typedef enum {
        FRAME_ANY,
        FRAME_NEAR_THRESH,
        FRAME_OFF_LINE,
        FRAME_RAILS,
        FRAME_HARD_RIGHT
    } frame_kind_t;

    // ------------------------------------------------------------------------
    // steering predictor and expected result store
    // ------------------------------------------------------------------------
    class steering_scoreboard;
        logic [THRESH_W-1:0]       line_thresh;
        logic signed [SPEED_W-1:0] base_speed;
        logic signed [GAIN_W-1:0]  kp;
        logic signed [GAIN_W-1:0]  ki;
        logic signed [GAIN_W-1:0]  kd;
        logic signed [ERR_W-1:0]   last_error;
        logic signed [INTEG_W-1:0] integ;
        wheel_result_t             speeds_q[$];
        int failures;
        int seen_count;
        int integ_clamps;
        int speed_clamps;

        function new();
            line_thresh  = 12'd1700;
            base_speed   = 16'sd2560;
            kp           = 24'sd6711;
            ki           = '0;
            kd           = '0;
            last_error   = '0;
            integ        = '0;
            failures     = 0;
            seen_count   = 0;
            integ_clamps = 0;
            speed_clamps = 0;
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // register write, unknown indexes leave everything as it was
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                lpps_pkg::CFG_LINE_THRESHOLD: line_thresh = data[THRESH_W-1:0];
                lpps_pkg::CFG_BASE_SPEED:     base_speed  = data[SPEED_W-1:0];
                lpps_pkg::CFG_PROP_GAIN:      kp          = data[GAIN_W-1:0];
                lpps_pkg::CFG_INTEG_GAIN:     ki          = data[GAIN_W-1:0];
                lpps_pkg::CFG_DERIV_GAIN:     kd          = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted frame: run one pid step and queue the speeds it gives
        function void note_frame(frame_t f);
            longint        pos;
            longint        acc;
            longint        sum;
            longint        corr;
            longint        r;
            longint        l;
            bit            hit;
            wheel_result_t want;
            pos = 0;
            hit = 1'b0;
            foreach (f[i]) begin
                if (f[i] < line_thresh)
                    hit = 1'b1;
                pos += POS_WEIGHT[i] * longint'(f[i]);
            end
            if (hit) begin
                pos = clip(pos, SPEED_LO, SPEED_HI);
                acc = longint'(integ) + longint'(ki) * pos;
                if (acc > INTEG_HI || acc < INTEG_LO)
                    integ_clamps++;
                integ = INTEG_W'(clip(acc, INTEG_LO, INTEG_HI));
                sum = longint'(kp) * pos + longint'(integ)
                    + longint'(kd) * (pos - longint'(last_error));
                last_error = ERR_W'(pos);
                // arithmetic shift floors toward minus infinity
                corr = sum >>> GAIN_SHIFT;
                r = longint'(base_speed) + corr;
                l = longint'(base_speed) - corr;
                if (r != clip(r, SPEED_LO, SPEED_HI) || l != clip(l, SPEED_LO, SPEED_HI))
                    speed_clamps++;
                r = clip(r, SPEED_LO, SPEED_HI);
                l = clip(l, SPEED_LO, SPEED_HI);
                seen_count++;
            end else begin
                pos = 0;
                r = longint'(base_speed);
                l = longint'(base_speed);
            end
            want.right = SPEED_W'(r);
            want.left  = SPEED_W'(l);
            want.seen  = hit;
            want.err   = ERR_W'(pos);
            speeds_q.push_back(want);
        endfunction

        // accepted result against the oldest expectation
        function void check_result(wheel_result_t got);
            wheel_result_t want;
            if (speeds_q.size() == 0) begin
                $error("wheel speed result with no frame pending");
                failures++;
                return;
            end
            want = speeds_q.pop_front();
            if (got.right !== want.right) begin
                $error("right_speed: expected %0d, got %0d", want.right, got.right);
                failures++;
            end
            if (got.left !== want.left) begin
                $error("left_speed: expected %0d, got %0d", want.left, got.left);
                failures++;
            end
            if (got.seen !== want.seen) begin
                $error("line_seen: expected %0d, got %0d", want.seen, got.seen);
                failures++;
            end
            if (got.err !== want.err) begin
                $error("line_error: expected %0d, got %0d", want.err, got.err);
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic aclk;
    logic aresetn = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [READING_BITS-1:0] s_reading_0 = '0;
    logic [READING_BITS-1:0] s_reading_1 = '0;
    logic [READING_BITS-1:0] s_reading_2 = '0;
    logic [READING_BITS-1:0] s_reading_3 = '0;
    logic [READING_BITS-1:0] s_reading_4 = '0;
    logic [READING_BITS-1:0] s_reading_5 = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [SPEED_W-1:0] m_right_speed;
    logic signed [SPEED_W-1:0] m_left_speed;
    logic                      m_line_seen;
    logic signed [ERR_W-1:0]   m_line_error;

    steering_scoreboard sb;
    int frames_sent = 0;
    int cfg_writes  = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    line_position_pid_steering_top u_dut (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one register write request, valid is lowered by the caller
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    // full register setting, with a write to an unused index mixed in
    task automatic apply_setting(input logic [THRESH_W-1:0] thr,
                                 input logic signed [SPEED_W-1:0] spd,
                                 input logic signed [GAIN_W-1:0] p_gain,
                                 input logic signed [GAIN_W-1:0] i_gain,
                                 input logic signed [GAIN_W-1:0] d_gain);
        logic [CFG_INDEX_W-1:0] junk_idx;
        junk_idx = CFG_INDEX_W'($urandom_range(int'(lpps_pkg::CFG_DERIV_GAIN) + 1,
                                               2 ** CFG_INDEX_W - 1));
        write_reg(lpps_pkg::CFG_LINE_THRESHOLD, {12'($urandom), thr});
        write_reg(junk_idx, 24'($urandom));
        write_reg(lpps_pkg::CFG_BASE_SPEED, {8'($urandom), spd});
        write_reg(lpps_pkg::CFG_PROP_GAIN, p_gain);
        write_reg(lpps_pkg::CFG_INTEG_GAIN, i_gain);
        write_reg(lpps_pkg::CFG_DERIV_GAIN, d_gain);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // one frame request, with a random gap ahead of it
    task automatic send_frame(input frame_t f);
        int gap;
        if (frames_sent % 50 == 0)
            tx_steady = ($urandom_range(0, 3) == 0);
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_reading_0 <= f[0];
        s_reading_1 <= f[1];
        s_reading_2 <= f[2];
        s_reading_3 <= f[3];
        s_reading_4 <= f[4];
        s_reading_5 <= f[5];
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_frame(f);
        frames_sent++;
    endtask

    // hold off until every queued result is back and the pipe is empty
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.speeds_q.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    function automatic frame_t frame_of(frame_kind_t kind);
        frame_t f;
        int     v;
        foreach (f[i]) begin
            case (kind)
                FRAME_ANY: f[i] = READING_BITS'($urandom);
                FRAME_NEAR_THRESH: begin
                    v = int'(sb.line_thresh) - 1 + $urandom_range(0, 2);
                    f[i] = READING_BITS'((v < 0) ? 0 : ((v > READ_MAX) ? READ_MAX : v));
                end
                FRAME_OFF_LINE: f[i] = READING_BITS'($urandom_range(sb.line_thresh, READ_MAX));
                FRAME_RAILS: f[i] = $urandom_range(0, 1) ? '1 : '0;
                // dark on the left, bright on the right: near the largest error
                FRAME_HARD_RIGHT: f[i] = (i < SENSOR_COUNT / 2)
                                       ? READING_BITS'($urandom_range(0, 63))
                                       : READING_BITS'($urandom_range(READ_MAX - 63, READ_MAX));
                default: f[i] = '0;
            endcase
        end
        return f;
    endfunction

    task automatic run_mixed(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                send_frame(frame_of(FRAME_ANY));
            else if (pick < 14)
                send_frame(frame_of(FRAME_NEAR_THRESH));
            else if (pick < 17)
                send_frame(frame_of(FRAME_OFF_LINE));
            else
                send_frame(frame_of(FRAME_RAILS));
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, with steady stretches
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        int taken;
        taken = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken % 40 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            stall = rx_steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            taken++;
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        wheel_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.right = m_right_speed;
            got.left  = m_left_speed;
            got.seen  = m_line_seen;
            got.err   = m_line_error;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no request moving anywhere
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                    || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        frame_t directed_q[$];
        frame_t f;
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames under reset values
        directed_q.push_back('{default: '0});
        directed_q.push_back('{default: '1});
        directed_q.push_back('{'0, '0, '0, '1, '1, '1});
        directed_q.push_back('{'1, '1, '1, '0, '0, '0});
        directed_q.push_back('{'0, '1, '0, '1, '0, '1});
        directed_q.push_back('{'1, '0, '1, '0, '1, '0});
        directed_q.push_back('{default: 12'hAAA});
        directed_q.push_back('{default: 12'h555});
        // every reading exactly at the threshold does not count as seen
        directed_q.push_back('{default: sb.line_thresh});
        // one sensor just under the threshold at each position
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            f = '{default: '1};
            f[i] = sb.line_thresh - 1'b1;
            directed_q.push_back(f);
        end
        foreach (directed_q[i])
            send_frame(directed_q[i]);
        run_mixed(4);
        drain();

        // long push with full integral gain drives the integral into its clamp
        apply_setting('1, '0, '0, GAIN_MAX, '0);
        repeat (640) send_frame(frame_of(FRAME_HARD_RIGHT));
        drain();

        // zero threshold: the line is never seen, speeds follow the base
        apply_setting('0, SPEED_MIN, GAIN_MAX, GAIN_MAX, GAIN_MIN);
        run_mixed(30);
        drain();

        // fully random setting
        apply_setting(12'($urandom), 16'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom));
        run_mixed(120);
        drain();

        // gain extremes against top base speed, both speeds clamp
        apply_setting(12'd2048, SPEED_MAX, GAIN_MIN, GAIN_MIN, GAIN_MAX);
        run_mixed(90);
        drain();

        // small gains keep speeds inside range, exercising floor rounding
        apply_setting(12'($urandom_range(1000, 3000)), 16'($urandom_range(0, 8191) - 4096),
                      24'($urandom_range(0, 8191) - 4096),
                      24'($urandom_range(0, 255) - 128),
                      24'($urandom_range(0, 8191) - 4096));
        run_mixed(90);
        drain();

        // highest threshold, largest proportional gain and most negative derivative
        apply_setting('1, SPEED_MIN, GAIN_MAX, '0, GAIN_MIN);
        run_mixed(40);
        drain();
        repeat (2 * PIPE_LATENCY) @(posedge aclk);

        if (sb.speeds_q.size() != 0)
            $error("%0d expected results never arrived", sb.speeds_q.size());
        $display("covered %0d frames (%0d with the line seen) over seven settings, %0d reg writes",
                 frames_sent, sb.seen_count, cfg_writes);
        $display("integral clamped %0d times, wheel speeds clamped %0d times",
                 sb.integ_clamps, sb.speed_clamps);
        if (sb.failures == 0 && sb.speeds_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
